// ===== src/bsa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Banker's safety allocator package
// Sizes, amount types, mode and status codes shared by the allocator files.
// ----------------------------------------------------------------------------
package bsa_pkg;

    localparam int CUSTOMERS   = 8;
    localparam int RESOURCES   = 4;
    localparam int AMOUNT_BITS = 8;

    localparam int FIELD_BITS = 8;
    localparam int CUST_BITS  = 3;
    localparam int CW         = (CUSTOMERS > 1) ? $clog2(CUSTOMERS) : 1;
    localparam int WW         = AMOUNT_BITS + $clog2(CUSTOMERS + 1);
    localparam int AMAX       = (1 << AMOUNT_BITS) - 1;

    typedef logic [AMOUNT_BITS-1:0]          t_amt;
    typedef t_amt [RESOURCES-1:0]            t_vec;
    typedef logic [RESOURCES-1:0][WW-1:0]    t_work;
    typedef logic [CW-1:0]                   t_cidx;

    typedef enum logic [1:0] {
        MODE_REQUEST   = 2'd0,
        MODE_RELEASE   = 2'd1,
        MODE_SET_MAX   = 2'd2,
        MODE_SET_AVAIL = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_GRANTED     = 3'd0,
        ST_EXCEEDS     = 3'd1,
        ST_WAIT        = 3'd2,
        ST_UNSAFE      = 3'd3,
        ST_OVERRELEASE = 3'd4,
        ST_LOADED      = 3'd5
    } t_status;

    function automatic t_amt sat_in(input logic [FIELD_BITS-1:0] v);
        if (32'(v) > AMAX) begin
            return '1;
        end
        return AMOUNT_BITS'(v);
    endfunction

    function automatic t_amt sat_add(input t_amt a, input t_amt b);
        logic [AMOUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[AMOUNT_BITS]) begin
            return '1;
        end
        return s[AMOUNT_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== src/bsa_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface bsa_req_if;
    import bsa_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [1:0]            mode;
    logic [CUST_BITS-1:0]  customer;
    logic [FIELD_BITS-1:0] amount_0;
    logic [FIELD_BITS-1:0] amount_1;
    logic [FIELD_BITS-1:0] amount_2;
    logic [FIELD_BITS-1:0] amount_3;

    modport source (output valid, mode, customer, amount_0, amount_1, amount_2, amount_3,
                    input ready);
    modport sink   (input valid, mode, customer, amount_0, amount_1, amount_2, amount_3,
                    output ready);
endinterface

interface bsa_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic       safe_state;

    modport source (output valid, status, safe_state, input ready);
    modport sink   (input valid, status, safe_state, output ready);
endinterface
`default_nettype wire

// ===== src/bankers_safety_allocator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Banker's safety allocator
// Request, release and table loading with a sequential safety check.
// ----------------------------------------------------------------------------
// One item is taken at a time. After acceptance the customer's row is read
// from the allocation and need memories, the item's effect is formed, and the
// safety check scans the rows, one per cycle through the memory read port,
// in passes over all rows until no customer can finish, with 1 to CUSTOMERS
// passes; an unsafe request runs the check a second time on the restored
// state. Tables reset to zero through per-row valid bits, so no clearing
// pass is needed. The result is held in an output register until taken.
// ----------------------------------------------------------------------------
module bankers_safety_allocator (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bsa_req_if.sink    i_req,
    bsa_res_if.source  o_res
);
    import bsa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_READ  = 3'b010,
        S_CHECK = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [1:0] r_mode, n_mode;
    t_cidx   r_ci, n_ci;
    logic    r_ok, n_ok;
    t_vec    r_amt, n_amt;
    t_vec    r_avail, n_avail;
    t_vec    r_cand_avail, n_cand_avail;
    t_vec    r_cand_alloc, n_cand_alloc;
    t_vec    r_cand_need, n_cand_need;
    logic    r_ovr, n_ovr;
    logic    r_try, n_try;
    t_status r_status, n_status;
    t_work   r_work, n_work;
    logic [CUSTOMERS-1:0] r_done, n_done;
    logic [CUSTOMERS-1:0] r_valid, n_valid;
    logic    r_prog, n_prog;
    t_cidx   r_c, n_c;
    logic    r_out_valid, n_out_valid;
    t_status r_out_status, n_out_status;
    logic    r_out_safe, n_out_safe;

    t_vec alloc_mem [CUSTOMERS];
    t_vec need_mem  [CUSTOMERS];
    t_vec rd_alloc, rd_need;
    logic r_rd_vld;
    t_cidx rd_addr;
    logic  wr_en;

    t_vec row_alloc, row_need, cur_alloc, cur_need;
    logic [FIELD_BITS-1:0] in_amt [RESOURCES];
    logic fits, last, safe, over, exceeds, waits, accept;
    logic [CUSTOMERS-1:0] done_nx;

    assign accept = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE) && (!r_out_valid || o_res.ready);
    assign o_res.valid = r_out_valid;
    assign o_res.status = r_out_status;
    assign o_res.safe_state = r_out_safe;

    always_comb begin
        in_amt[0] = i_req.amount_0;
        if (RESOURCES > 1) in_amt[RESOURCES > 1 ? 1 : 0] = i_req.amount_1;
        if (RESOURCES > 2) in_amt[RESOURCES > 2 ? 2 : 0] = i_req.amount_2;
        if (RESOURCES > 3) in_amt[RESOURCES > 3 ? 3 : 0] = i_req.amount_3;
    end

    always_ff @(posedge i_clk) begin
        rd_alloc <= alloc_mem[rd_addr];
        rd_need  <= need_mem[rd_addr];
        r_rd_vld <= r_valid[rd_addr];
        if (wr_en) begin
            alloc_mem[r_ci] <= r_cand_alloc;
            need_mem[r_ci]  <= r_cand_need;
        end
    end

    assign row_alloc = r_rd_vld ? rd_alloc : '0;
    assign row_need  = r_rd_vld ? rd_need  : '0;
    assign cur_alloc = (r_ovr && r_c == r_ci) ? r_cand_alloc : row_alloc;
    assign cur_need  = (r_ovr && r_c == r_ci) ? r_cand_need  : row_need;
    assign last      = (r_c == CW'(CUSTOMERS - 1));

    always_comb begin
        n_state = r_state;       n_mode = r_mode;         n_ci = r_ci;
        n_ok = r_ok;             n_amt = r_amt;           n_avail = r_avail;
        n_cand_avail = r_cand_avail; n_cand_alloc = r_cand_alloc;
        n_cand_need = r_cand_need;   n_ovr = r_ovr;       n_try = r_try;
        n_status = r_status;     n_work = r_work;         n_done = r_done;
        n_valid = r_valid;       n_prog = r_prog;         n_c = r_c;
        n_out_valid = r_out_valid; n_out_status = r_out_status;
        n_out_safe = r_out_safe;
        rd_addr = r_c;
        wr_en = 1'b0;
        over = 1'b0;
        exceeds = 1'b0;
        waits = 1'b0;
        safe = 1'b0;
        fits = 1'b0;
        done_nx = r_done;

        if (o_res.valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                n_ok = 32'(i_req.customer) < CUSTOMERS;
                n_ci = n_ok ? CW'(i_req.customer) : '0;
                rd_addr = n_ci;
                if (accept) begin
                    n_mode = i_req.mode;
                    for (int r = 0; r < RESOURCES; r++) begin
                        n_amt[r] = sat_in(in_amt[r]);
                    end
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_cand_avail = r_avail;
                n_cand_alloc = row_alloc;
                n_cand_need  = row_need;
                n_ovr = 1'b0;
                n_try = 1'b0;
                case (r_mode)
                    MODE_SET_AVAIL: begin
                        n_cand_avail = r_amt;
                        n_status = ST_LOADED;
                    end
                    MODE_SET_MAX: begin
                        n_ovr = r_ok;
                        for (int r = 0; r < RESOURCES; r++) begin
                            n_cand_need[r] = (r_amt[r] > row_alloc[r]) ?
                                             t_amt'(r_amt[r] - row_alloc[r]) : '0;
                        end
                        n_status = ST_LOADED;
                    end
                    MODE_RELEASE: begin
                        over = !r_ok;
                        for (int r = 0; r < RESOURCES; r++) begin
                            if (r_amt[r] > row_alloc[r]) over = 1'b1;
                        end
                        if (over) begin
                            n_status = ST_OVERRELEASE;
                        end else begin
                            n_ovr = 1'b1;
                            for (int r = 0; r < RESOURCES; r++) begin
                                n_cand_alloc[r] = row_alloc[r] - r_amt[r];
                                n_cand_need[r]  = sat_add(row_need[r], r_amt[r]);
                                n_cand_avail[r] = sat_add(r_avail[r], r_amt[r]);
                            end
                            n_status = ST_GRANTED;
                        end
                    end
                    default: begin
                        exceeds = !r_ok;
                        for (int r = 0; r < RESOURCES; r++) begin
                            if (r_amt[r] > row_need[r]) exceeds = 1'b1;
                            if (r_amt[r] > r_avail[r]) waits = 1'b1;
                        end
                        if (exceeds) begin
                            n_status = ST_EXCEEDS;
                        end else if (waits) begin
                            n_status = ST_WAIT;
                        end else begin
                            n_ovr = 1'b1;
                            n_try = 1'b1;
                            for (int r = 0; r < RESOURCES; r++) begin
                                n_cand_avail[r] = r_avail[r] - r_amt[r];
                                n_cand_alloc[r] = sat_add(row_alloc[r], r_amt[r]);
                                n_cand_need[r]  = row_need[r] - r_amt[r];
                            end
                            n_status = ST_GRANTED;
                        end
                    end
                endcase
                for (int r = 0; r < RESOURCES; r++) begin
                    n_work[r] = WW'(n_cand_avail[r]);
                end
                n_done = '0;
                n_prog = 1'b0;
                n_c = '0;
                rd_addr = '0;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                fits = !r_done[r_c];
                for (int r = 0; r < RESOURCES; r++) begin
                    if (WW'(cur_need[r]) > r_work[r]) fits = 1'b0;
                end
                if (fits) begin
                    done_nx[r_c] = 1'b1;
                    for (int r = 0; r < RESOURCES; r++) begin
                        n_work[r] = r_work[r] + WW'(cur_alloc[r]);
                    end
                end
                n_done = done_nx;
                safe = &done_nx;
                if (last && (safe || !(r_prog || fits))) begin
                    if (r_try && !safe) begin
                        n_status = ST_UNSAFE;
                        n_ovr = 1'b0;
                        n_try = 1'b0;
                        n_cand_avail = r_avail;
                        for (int r = 0; r < RESOURCES; r++) begin
                            n_work[r] = WW'(r_avail[r]);
                        end
                        n_done = '0;
                        n_prog = 1'b0;
                        n_c = '0;
                        rd_addr = '0;
                    end else begin
                        wr_en = r_ovr;
                        if (r_ovr) n_valid[r_ci] = 1'b1;
                        n_avail = r_cand_avail;
                        n_out_valid = 1'b1;
                        n_out_status = r_status;
                        n_out_safe = safe;
                        n_state = S_IDLE;
                    end
                end else if (last) begin
                    n_c = '0;
                    n_prog = 1'b0;
                    rd_addr = '0;
                end else begin
                    n_c = r_c + 1'b1;
                    n_prog = r_prog | fits;
                    rd_addr = n_c;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_avail     <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_avail     <= n_avail;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
        r_mode <= n_mode;             r_ci <= n_ci;               r_ok <= n_ok;
        r_amt <= n_amt;               r_cand_avail <= n_cand_avail;
        r_cand_alloc <= n_cand_alloc; r_cand_need <= n_cand_need;
        r_ovr <= n_ovr;               r_try <= n_try;             r_status <= n_status;
        r_work <= n_work;             r_done <= n_done;           r_prog <= n_prog;
        r_c <= n_c;                   r_out_status <= n_out_status;
        r_out_safe <= n_out_safe;
    end

endmodule
`default_nettype wire
